>>> sv/ax25tnc_pkg.sv
// Shared types, codes and helpers for the AX.25 to TNC2 monitor decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ax25tnc_pkg;

  // Frame parse phases
  typedef enum logic [2:0] {
    PH_ADDR    = 3'd0,
    PH_CTRL    = 3'd1,
    PH_PID     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DISCARD = 3'd4
  } phase_e;

  // Controller states: take input beats, or walk the header text
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SRC   = 3'd1,
    ST_GT    = 3'd2,
    ST_DST   = 3'd3,
    ST_COLON = 3'd4
  } state_e;

  // What the output register loads
  typedef enum logic [2:0] {
    OUT_REJ      = 3'd0,
    OUT_BYTE     = 3'd1,
    OUT_SRC_CHAR = 3'd2,
    OUT_DST_CHAR = 3'd3,
    OUT_GT       = 3'd4,
    OUT_COLON    = 3'd5
  } out_kind_e;

  // Text slots of one address: callsign bytes 0..5, then the SSID suffix
  localparam logic [3:0] SLOT_DASH  = 4'd6;
  localparam logic [3:0] SLOT_ONE   = 4'd7;
  localparam logic [3:0] SLOT_DIGIT = 4'd8;
  localparam logic [3:0] SLOT_DONE  = 4'd9;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [3:0] SSID_TEN = 4'd10;

  typedef logic [6:0][7:0] field_t;

  typedef struct packed {
    logic [3:0] first;     // first slot to emit, SLOT_DONE when nothing
    logic [2:0] hi;        // last callsign slot kept after trimming
    logic       ssid_nz;
    logic       ssid_ge10;
  } field_info_t;

  typedef struct packed {
    logic       wr_dest;
    logic       wr_src;
    logic [2:0] wr_idx;
    logic       out_load;
    out_kind_e  out_kind;
    logic [3:0] out_slot;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic        out_free;
    field_info_t src_info;
    field_info_t dst_info;
  } dp_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Trim bounds and SSID flags of one stored address field
  function automatic field_info_t field_info(input field_t f);
    field_info_t info;
    logic [5:0]  ws;
    logic [2:0]  lo;
    logic [2:0]  hi;
    logic [3:0]  ssid;
    lo = 3'd6;
    hi = 3'd0;
    for (int i = 0; i < 6; i++) begin
      ws[i] = is_ws({1'b0, f[i][7:1]});
    end
    for (int i = 5; i >= 0; i--) begin
      if (!ws[i]) lo = 3'(i);
    end
    for (int i = 0; i < 6; i++) begin
      if (!ws[i]) hi = 3'(i);
    end
    ssid           = f[6][4:1];
    info.ssid_nz   = (ssid != 4'd0);
    info.ssid_ge10 = (ssid >= SSID_TEN);
    info.hi        = hi;
    if (!(&ws)) begin
      info.first = {1'b0, lo};
    end else begin
      info.first = info.ssid_nz ? SLOT_DASH : SLOT_DONE;
    end
    return info;
  endfunction

endpackage

`default_nettype wire

>>> sv/ax25tnc_dp.sv
// Datapath of the AX.25 to TNC2 decoder: address field store, trim logic,
// character select and the output register. Depends on ax25tnc_pkg.
`default_nettype none

module ax25tnc_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         frame_byte_i,
  input  wire ax25tnc_pkg::dp_cmd_t  cmd_i,
  output ax25tnc_pkg::dp_stat_t   stat_o,
  input  wire logic               m_ready_i,
  output logic                    m_valid_o,
  output logic [7:0]              m_char_o,
  output logic                    m_last_o,
  output logic                    m_rej_o
);
  import ax25tnc_pkg::*;

  field_t      dest_q;
  field_t      src_q;
  field_info_t src_info;
  field_info_t dst_info;
  logic        out_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        rej_q;
  logic [7:0]  char_d;
  logic        rej_d;

  function automatic logic [7:0] field_char(input field_t f, input field_info_t info,
                                            input logic [3:0] slot);
    logic [3:0] digit;
    logic [7:0] c;
    digit = info.ssid_ge10 ? (f[6][4:1] - SSID_TEN) : f[6][4:1];
    case (slot)
      SLOT_DASH:  c = CHAR_DASH;
      SLOT_ONE:   c = CHAR_ONE;
      SLOT_DIGIT: c = CHAR_ZERO + {4'd0, digit};
      default: begin
        if (slot < SLOT_DASH) c = {1'b0, f[slot[2:0]][7:1]};
        else                  c = 8'd0;
      end
    endcase
    return c;
  endfunction

  assign src_info = field_info(src_q);
  assign dst_info = field_info(dest_q);

  assign stat_o.out_free = !out_valid_q || m_ready_i;
  assign stat_o.src_info = src_info;
  assign stat_o.dst_info = dst_info;

  // Store address bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_dest) dest_q[cmd_i.wr_idx] <= frame_byte_i;
    if (cmd_i.wr_src)  src_q[cmd_i.wr_idx]  <= frame_byte_i;
  end

  always_comb begin
    rej_d = 1'b0;
    unique case (cmd_i.out_kind)
      OUT_REJ: begin
        char_d = 8'd0;
        rej_d  = 1'b1;
      end
      OUT_BYTE:     char_d = frame_byte_i;
      OUT_SRC_CHAR: char_d = field_char(src_q, src_info, cmd_i.out_slot);
      OUT_DST_CHAR: char_d = field_char(dest_q, dst_info, cmd_i.out_slot);
      OUT_GT:       char_d = CHAR_GT;
      OUT_COLON:    char_d = CHAR_COLON;
      default:      char_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      char_q <= char_d;
      last_q <= cmd_i.out_last;
      rej_q  <= rej_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = char_q;
  assign m_last_o  = last_q;
  assign m_rej_o   = rej_q;

endmodule

`default_nettype wire

>>> sv/ax25tnc_ctrl.sv
// Controller of the AX.25 to TNC2 decoder: frame parse phases, address
// counters and the header walk sequencer. Depends on ax25tnc_pkg.
`default_nettype none

module ax25tnc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic                  frame_bit0_i,
  input  wire logic                  frame_end_i,
  input  wire ax25tnc_pkg::dp_stat_t stat_i,
  output ax25tnc_pkg::dp_cmd_t       cmd_o
);
  import ax25tnc_pkg::*;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [2:0] gp_q, gp_d;
  logic [1:0] ac_q, ac_d;
  logic [1:0] ac_inc;
  logic [3:0] slot_q, slot_d;
  logic       hdr_last_q, hdr_last_d;

  function automatic logic [3:0] next_slot(input logic [3:0] slot, input field_info_t info);
    logic [3:0] n;
    if (slot < {1'b0, info.hi}) begin
      n = slot + 4'd1;
    end else if (slot < SLOT_DASH) begin
      n = info.ssid_nz ? SLOT_DASH : SLOT_DONE;
    end else if (slot == SLOT_DASH) begin
      n = info.ssid_ge10 ? SLOT_ONE : SLOT_DIGIT;
    end else if (slot == SLOT_ONE) begin
      n = SLOT_DIGIT;
    end else begin
      n = SLOT_DONE;
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_ADDR;
      gp_q       <= 3'd0;
      ac_q       <= 2'd0;
      slot_q     <= SLOT_DONE;
      hdr_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      gp_q       <= gp_d;
      ac_q       <= ac_d;
      slot_q     <= slot_d;
      hdr_last_q <= hdr_last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    gp_d       = gp_q;
    ac_d       = ac_q;
    slot_d     = slot_q;
    hdr_last_d = hdr_last_q;
    ac_inc     = (ac_q < 2'd3) ? (ac_q + 2'd1) : ac_q;
    s_ready_o  = 1'b0;
    cmd_o          = '0;
    cmd_o.out_kind = OUT_REJ;
    cmd_o.out_slot = slot_q;
    cmd_o.wr_idx   = gp_q;

    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = stat_i.out_free;
        if (s_valid_i && stat_i.out_free) begin
          unique case (phase_q)
            PH_ADDR: begin
              cmd_o.wr_dest = (ac_q == 2'd0);
              cmd_o.wr_src  = (ac_q == 2'd1);
              if (gp_q >= 3'd6) begin
                gp_d = 3'd0;
                ac_d = ac_inc;
                if (frame_bit0_i) phase_d = (ac_inc >= 2'd2) ? PH_CTRL : PH_DISCARD;
              end else begin
                gp_d = gp_q + 3'd1;
              end
              cmd_o.out_load = frame_end_i;
              cmd_o.out_last = 1'b1;
            end
            PH_CTRL: begin
              phase_d        = PH_PID;
              cmd_o.out_load = frame_end_i;
              cmd_o.out_last = 1'b1;
            end
            PH_PID: begin
              phase_d    = PH_PAYLOAD;
              state_d    = ST_SRC;
              slot_d     = stat_i.src_info.first;
              hdr_last_d = frame_end_i;
            end
            PH_PAYLOAD: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_kind = OUT_BYTE;
              cmd_o.out_last = frame_end_i;
            end
            default: begin
              cmd_o.out_load = frame_end_i;
              cmd_o.out_last = 1'b1;
            end
          endcase
          // Return to the address phase after any last byte
          if (frame_end_i) begin
            phase_d = PH_ADDR;
            gp_d    = 3'd0;
            ac_d    = 2'd0;
          end
        end
      end
      ST_SRC: begin
        if (slot_q == SLOT_DONE) begin
          state_d = ST_GT;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_SRC_CHAR;
          slot_d         = next_slot(slot_q, stat_i.src_info);
        end
      end
      ST_GT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_GT;
          slot_d         = stat_i.dst_info.first;
          state_d        = ST_DST;
        end
      end
      ST_DST: begin
        if (slot_q == SLOT_DONE) begin
          state_d = ST_COLON;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_DST_CHAR;
          slot_d         = next_slot(slot_q, stat_i.dst_info);
        end
      end
      ST_COLON: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_COLON;
          cmd_o.out_last = hdr_last_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ax25_to_tnc2_monitor_decoder_top.sv
// AX.25 frame to TNC2 monitor text decoder, top level.
// Depends on ax25tnc_pkg, ax25tnc_ctrl and ax25tnc_dp.
//
// Usage:
// - Slave stream: one AX.25 frame byte per beat on s_axis_tdata_i, with
//   s_axis_tlast_i high on the last byte of the frame.
// - Master stream: one text character per beat on m_axis_tdata_o; tlast
//   marks the final character of a frame's line, tuser marks a rejected
//   frame (a single beat with data 0 and tlast set).
// - Address, control and discarded bytes give no beat, except a last byte
//   of a malformed frame, which gives the reject.
// - Payload bytes pass through, each shown in the cycle after it is taken, one per cycle while the receiver keeps up.
// - On the PID byte the header "SRC>DEST:" (up to 20 characters) is emitted
//   from the stored address fields, one character at a time, while input
//   is held off; the header walk is set by the controller's slot
//   sequencer.
// - A single output register parts the two sides; a new byte is taken when
//   the register is empty or being read in the same cycle.
// - When the receiver stalls, hold the current beat; the header walk and
//   input acceptance stop until the beat is taken.
// - Reset clears the parse phase, counters and the output valid; stored
//   address bytes are only read after being written within a frame.
`default_nettype none

module ax25_to_tnc2_monitor_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] frame_byte
  input  wire logic       s_axis_tlast_i,   // frame_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] text_char
  output logic            m_axis_tlast_o,   // text_last
  output logic            m_axis_tuser_o    // rejected
);
  import ax25tnc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Parse phases and header sequencing
  ax25tnc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .frame_bit0_i (s_axis_tdata_i[0]),
    .frame_end_i  (s_axis_tlast_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Address store, character build and output register
  ax25tnc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_byte_i (s_axis_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_o    (m_axis_tvalid_o),
    .m_char_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o),
    .m_rej_o      (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for ax25_to_tnc2_monitor_decoder_top.
// Streams AX.25 frames in, decodes them into TNC2 text alongside, checks each beat out.
// Depends on ax25tnc_pkg and the decoder RTL only.
`default_nettype none

module tb_top;
  import ax25tnc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned PHASE_BEATS  = 40;    // beats per idling phase
  localparam int unsigned SQUEEZE_AT   = 100;   // input beat count that starts the hold-off
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_BURST    = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       rej;
  } text_beat_t;

  logic       clk;
  logic       rst_n   = 1'b0;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_data  = 8'h00;
  logic       s_last  = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic       m_last;
  logic       m_rej;

  frame_beat_t beats_q[$];      // frame bytes waiting to be offered
  text_beat_t  text_q[$];       // decoded text still owed by the block
  logic [7:0]  frame_buf[$];    // frame under construction

  logic        in_taken  = 1'b0;
  logic        hold_off  = 1'b0;
  int unsigned beats_in  = 0;
  int unsigned cycles    = 0;
  int unsigned errors    = 0;

  // Decoder state kept alongside the block
  phase_e      ph       = PH_ADDR;
  logic [2:0]  grp      = 3'd0;
  logic [1:0]  naddr    = 2'd0;
  field_t      dst_f    = '0;
  field_t      src_f    = '0;
  int unsigned burst_n;

  ax25_to_tnc2_monitor_decoder_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_rej)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // Text decoder
  //--------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Queue one expected character; a burst never exceeds the header size
  task automatic expect_text(input logic [7:0] ch, input logic last, input logic rej);
    if (burst_n < MAX_BURST) begin
      text_q.push_back('{ch: ch, last: last, rej: rej});
      burst_n++;
    end
  endtask

  // Callsign trimmed of blanks, then "-N" for a nonzero SSID
  task automatic emit_call_text(input field_t f);
    logic [7:0] cs[6];
    logic [3:0] ssid;
    int lo;
    int hi;
    for (int i = 0; i < 6; i++) cs[i] = {1'b0, f[i][7:1]};
    lo = 0;
    hi = 5;
    while (lo <= 5 && is_blank(cs[lo])) lo++;
    while (hi >= lo && is_blank(cs[hi])) hi--;
    for (int i = lo; i <= hi; i++) expect_text(cs[i], 1'b0, 1'b0);
    ssid = f[6][4:1];
    if (ssid != 4'd0) begin
      expect_text(CHAR_DASH, 1'b0, 1'b0);
      if (ssid >= SSID_TEN) begin
        expect_text(CHAR_ONE, 1'b0, 1'b0);
        ssid = ssid - SSID_TEN;
      end
      expect_text(CHAR_ZERO + 8'(ssid), 1'b0, 1'b0);
    end
  endtask

  // Advance the frame parse by one byte and queue whatever text it yields
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    burst_n = 0;
    case (ph)
      PH_ADDR: begin
        if (naddr == 2'd0) dst_f[grp] = b;
        else if (naddr == 2'd1) src_f[grp] = b;
        if (grp == 3'd6) begin
          grp = 3'd0;
          if (naddr != 2'd3) naddr = naddr + 2'd1;
          // extension bit closes the address part
          if (b[0]) ph = (naddr >= 2'd2) ? PH_CTRL : PH_DISCARD;
        end else begin
          grp = grp + 3'd1;
        end
        if (fin) expect_text(8'h00, 1'b1, 1'b1);
      end
      PH_CTRL: begin
        ph = PH_PID;
        if (fin) expect_text(8'h00, 1'b1, 1'b1);
      end
      PH_PID: begin
        emit_call_text(src_f);
        expect_text(CHAR_GT, 1'b0, 1'b0);
        emit_call_text(dst_f);
        expect_text(CHAR_COLON, fin, 1'b0);
        ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: expect_text(b, fin, 1'b0);
      default: begin
        if (fin) expect_text(8'h00, 1'b1, 1'b1);
      end
    endcase
    if (fin) begin
      ph    = PH_ADDR;
      grp   = 3'd0;
      naddr = 2'd0;
    end
  endtask

  //--------------------------------------------------------------------------
  // Frame builders
  //--------------------------------------------------------------------------
  // Move the frame under construction to the send queue, tlast on its final byte
  task automatic send_frame();
    foreach (frame_buf[i])
      beats_q.push_back('{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
    frame_buf.delete();
  endtask

  task automatic add_call(input string s, input logic [3:0] ssid, input logic ext);
    logic [7:0] ch;
    for (int i = 0; i < 6; i++) begin
      ch = (i < s.len()) ? s[i] : 8'h20;
      frame_buf.push_back({ch[6:0], 1'b0});
    end
    frame_buf.push_back({3'b011, ssid, ext});
  endtask

  // Random callsign mixing letters, digits, blanks and arbitrary codes
  task automatic add_rand_call(input logic ext);
    logic [6:0] ch;
    logic [3:0] ssid;
    logic       blank_all;
    blank_all = ($urandom_range(7) == 0);
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(9))
        0, 1, 2: ch = 7'h41 + 7'($urandom_range(25));
        3:       ch = 7'h30 + 7'($urandom_range(9));
        4, 5:    ch = 7'h20;
        6:       ch = 7'h09 + 7'($urandom_range(4));
        default: ch = 7'($urandom_range(127));
      endcase
      if (blank_all) ch = 7'h20;
      frame_buf.push_back({ch, 1'($urandom_range(7) == 0)});
    end
    ssid = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom);
    frame_buf.push_back({3'($urandom), ssid, ext});
  endtask

  task automatic add_rand_frame();
    int kind;
    int nrep;
    int cut;
    kind = $urandom_range(19);
    if (kind <= 15) begin
      // well-formed frame, sometimes cut short
      nrep = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      add_rand_call(1'b0);
      add_rand_call(nrep == 0);
      for (int r = 0; r < nrep; r++) add_rand_call(r == nrep - 1);
      frame_buf.push_back(8'($urandom));   // control
      frame_buf.push_back(8'($urandom));   // PID
      repeat ($urandom_range(16)) frame_buf.push_back(8'($urandom));
      if (kind >= 13) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end else if (kind == 16) begin
      // address part that never ends
      repeat ($urandom_range(1, 5)) add_rand_call(1'b0);
      repeat ($urandom_range(6)) frame_buf.push_back(8'($urandom));
    end else if (kind == 17) begin
      // single address field, rest discarded
      add_rand_call(1'b1);
      repeat ($urandom_range(12)) frame_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  //--------------------------------------------------------------------------
  // Driver: offer frame bytes and drive the receiver's ready at the falling edge
  //--------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    int unsigned mode;
    logic        idle;
    logic        stall;
    frame_beat_t nb;
    if (rst_n) begin
      // rotate: no idling, sender idle, receiver stalls, both lightly
      mode = (beats_in / PHASE_BEATS) % 4;
      if (!s_valid || in_taken) begin
        idle = (mode == 1) ? ($urandom_range(99) < 60) :
               (mode == 3) ? ($urandom_range(99) < 13) : 1'b0;
        if (beats_q.size() != 0 && !idle) begin
          nb = beats_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= nb.data;
          s_last  <= nb.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
      stall = (mode == 2) ? ($urandom_range(99) < 60) :
              (mode == 3) ? ($urandom_range(99) < 13) : 1'b0;
      m_ready <= !(hold_off || stall);
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: check text beats, then decode accepted frame bytes
  //--------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    text_beat_t want;
    in_taken <= s_valid && s_ready;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (text_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("cycle %0d: unexpected beat data %02h last %0b rej %0b",
                     cycles, m_data, m_last, m_rej);
        end else begin
          want = text_q.pop_front();
          if (m_data !== want.ch || m_last !== want.last || m_rej !== want.rej) begin
            errors++;
            if (errors <= 10)
              $display("cycle %0d: expected data %02h last %0b rej %0b, got %02h %0b %0b",
                       cycles, want.ch, want.last, want.rej, m_data, m_last, m_rej);
          end
        end
      end
      // a byte never yields text on the edge that accepts it
      if (s_valid && s_ready) begin
        decode_byte(s_data, s_last);
        beats_in <= beats_in + 1;
      end
    end
  end

  // Hold the receiver off for a long stretch so the block backs up its input
  initial begin : squeeze
    wait (beats_in >= SQUEEZE_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL ax25_to_tnc2_monitor_decoder_top");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus and end of run
  //--------------------------------------------------------------------------
  initial begin : main
    // ends inside the first address field
    frame_buf.push_back(8'hFF);
    send_frame();
    // blank destination, padded source with SSID 15, ends on PID: header only
    add_call("      ", 4'd0, 1'b0);
    add_call(" \tAB  ", 4'd15, 1'b1);
    frame_buf.push_back(8'h03);
    frame_buf.push_back(8'hF0);
    send_frame();
    // SSID 10 and 1, ends on the control byte
    add_call("N0CALL", 4'd10, 1'b0);
    add_call("X", 4'd1, 1'b1);
    frame_buf.push_back(8'h03);
    send_frame();
    // single address field, trailing bytes dropped
    add_call("Q", 4'd0, 1'b1);
    frame_buf.push_back(8'h03);
    frame_buf.push_back(8'hF0);
    send_frame();
    // one repeater, payload at both byte extremes
    add_call("APRS", 4'd0, 1'b0);
    add_call("F1ZZZ", 4'd9, 1'b0);
    add_call("WIDE1", 4'd1, 1'b1);
    frame_buf.push_back(8'h03);
    frame_buf.push_back(8'hF0);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    send_frame();

    while (beats_q.size() < RANDOM_BYTES) add_rand_frame();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (beats_q.size() != 0 || s_valid) @(posedge clk);
    while (text_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS ax25_to_tnc2_monitor_decoder_top");
    end else begin
      $display("FAIL ax25_to_tnc2_monitor_decoder_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
